// ===== hdl/hnm_pkg.sv =====
package hnm_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STRENGTH     = 2'd2;

    localparam int FIFO_DEPTH = 4;

    // one pixel job for the normal unit
    typedef struct packed {
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic [15:0]       row;
        logic [9:0]        col;
        logic              last;
        logic              eof;
    } job_t;

    // queue status seen by the front
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

// ===== hdl/hnm_ram.sv =====
module hnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/hnm_fifo.sv =====
module hnm_fifo import hnm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  job_t       push_job,
    input  logic       pop,
    output job_t       head,
    output fifo_stat_t stat
);

    localparam int PW = $clog2(FIFO_DEPTH);

    job_t          mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign head       = mem[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (PW+1)'(FIFO_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule

// ===== hdl/hnm_front.sv =====
module hnm_front import hnm_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_sample,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   width_eff,
    input  logic [15:0]                      height_eff,
    input  logic                             geom_clear,
    input  fifo_stat_t                       q_stat,
    output logic                             q_push,
    output job_t                             q_job
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH+1);

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_RD0  = 7'b0000010,
        F_RD1  = 7'b0000100,
        F_RD2  = 7'b0001000,
        F_EA   = 7'b0010000,
        F_EB   = 7'b0100000,
        F_EC   = 7'b1000000
    } fstate_t;

    fstate_t       state_reg, state_next;
    logic [AW-1:0] col_reg;
    logic [15:0]   row_reg;
    logic [7:0]    smp_reg, prev_reg, centre_reg, right_reg;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic [CW-1:0] col_plus;
    logic          has_right, row_last, cond_a, cond_b, cond_c;

    assign col_plus  = CW'(col_reg) + CW'(1);
    assign has_right = (col_plus < width_eff);
    assign row_last  = (row_reg == height_eff - 16'd1);
    assign cond_a    = (row_reg != 16'd0);
    assign cond_b    = row_last && (col_reg != '0);
    assign cond_c    = row_last && !has_right;
    assign in_ready  = (state_reg == F_IDLE);
    assign raddr     = (state_reg == F_RD1) ? col_reg + AW'(1) : col_reg;

    hnm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (state_reg == F_RD2),
        .waddr (col_reg),
        .wdata (smp_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // job build and push
    always_comb
    begin
        q_push = 1'b0;
        q_job  = '0;
        unique case (state_reg)
            F_EA:
            begin
                q_push     = cond_a && !q_stat.full;
                q_job.dx   = right_reg - centre_reg;
                q_job.dy   = smp_reg - centre_reg;
                q_job.row  = row_reg - 16'd1;
                q_job.col  = 10'(col_reg);
                q_job.last = !(cond_b || cond_c);
            end
            F_EB:
            begin
                q_push     = cond_b && !q_stat.full;
                q_job.dx   = smp_reg - prev_reg;
                q_job.row  = row_reg;
                q_job.col  = 10'(col_reg - AW'(1));
                q_job.last = !cond_c;
            end
            F_EC:
            begin
                q_push     = cond_c && !q_stat.full;
                q_job.row  = row_reg;
                q_job.col  = 10'(col_reg);
                q_job.last = 1'b1;
                q_job.eof  = 1'b1;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_RD0;
            F_RD0:  state_next = F_RD1;
            F_RD1:  state_next = F_RD2;
            F_RD2:  state_next = F_EA;
            F_EA:   if (!cond_a || !q_stat.full) state_next = F_EB;
            F_EB:   if (!cond_b || !q_stat.full) state_next = F_EC;
            F_EC:   if (!cond_c || !q_stat.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            smp_reg <= in_sample;
        end
        if (state_reg == F_RD1)
        begin
            centre_reg <= rdata;
        end
        if (state_reg == F_RD2)
        begin
            right_reg <= has_right ? rdata : centre_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (geom_clear)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (state_reg == F_EC && state_next == F_IDLE)
            begin
                prev_reg <= smp_reg;
                if (!has_right)
                begin
                    col_reg <= '0;
                    row_reg <= row_last ? 16'd0 : row_reg + 16'd1;
                end
                else
                begin
                    col_reg <= col_reg + AW'(1);
                end
            end
        end
    end

endmodule

// ===== hdl/hnm_back.sv =====
module hnm_back import hnm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [15:0] strength,
    input  fifo_stat_t         q_stat,
    input  job_t               q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_blue,
    output logic [7:0]         out_green,
    output logic [7:0]         out_red,
    output logic [15:0]        out_row,
    output logic [9:0]         out_col,
    output logic               out_last,
    output logic               out_eof
);

    typedef enum logic [11:0] {
        B_IDLE = 12'b000000000001,
        B_MULX = 12'b000000000010,
        B_MULY = 12'b000000000100,
        B_SQX  = 12'b000000001000,
        B_SQY  = 12'b000000010000,
        B_SUM  = 12'b000000100000,
        B_DIV  = 12'b000001000000,
        B_SQRT = 12'b000010000000,
        B_Z    = 12'b000100000000,
        B_TX   = 12'b001000000000,
        B_TY   = 12'b010000000000,
        B_OUT  = 12'b100000000000
    } bstate_t;

    bstate_t            state_reg;
    job_t               job_reg;
    logic signed [23:0] xq_reg, yq_reg, mul_x, mul_y;
    logic [22:0]        magx, magy;
    logic [45:0]        sqx_reg, sqy_reg;
    logic [46:0]        den_reg, rem_reg;
    logic [5:0]         cnt_reg;
    logic [32:0]        quo_reg, t_reg;
    logic [47:0]        shifted;
    logic               qbit;
    logic [33:0]        res_reg, bit_reg, trial, res_next;
    logic [16:0]        q_reg;
    logic [23:0]        z_reg;
    logic [46:0]        prod_x, prod_y;
    logic [7:0]         trx_reg, try_reg, trx_s, try_s;

    assign mul_x   = strength * job_reg.dx;
    assign mul_y   = strength * job_reg.dy;
    assign magx    = 23'(xq_reg[23] ? -xq_reg : xq_reg);
    assign magy    = 23'(yq_reg[23] ? -yq_reg : yq_reg);
    assign shifted = {rem_reg, (cnt_reg == 6'd48)};
    assign qbit    = (shifted >= 48'(den_reg));
    assign trial   = res_reg + bit_reg;
    assign res_next = (34'(t_reg) >= trial) ? (res_reg >> 1) + bit_reg : res_reg >> 1;
    assign prod_x  = magx * z_reg;
    assign prod_y  = magy * z_reg;
    assign trx_s   = xq_reg[23] ? 8'd0 - trx_reg : trx_reg;
    assign try_s   = yq_reg[23] ? 8'd0 - try_reg : try_reg;
    assign q_pop   = (state_reg == B_IDLE) && !q_stat.empty;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE: job_reg <= q_head;
            B_MULX: xq_reg <= mul_x;
            B_MULY: yq_reg <= mul_y;
            B_SQX:  sqx_reg <= magx * magx;
            B_SQY:  sqy_reg <= magy * magy;
            B_SUM:
            begin
                den_reg <= 47'(sqx_reg) + 47'(sqy_reg) + 47'd65536;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            B_DIV:
            begin
                rem_reg <= qbit ? 47'(shifted - 48'(den_reg)) : 47'(shifted);
                quo_reg <= {quo_reg[31:0], qbit};
                t_reg   <= {quo_reg[31:0], qbit};
                res_reg <= '0;
                bit_reg <= 34'd1 << 32;
            end
            B_SQRT:
            begin
                if (34'(t_reg) >= trial)
                begin
                    t_reg <= 33'(34'(t_reg) - trial);
                end
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
                q_reg   <= 17'(res_next);
            end
            B_Z:  z_reg <= 24'(q_reg) * 24'd127;
            B_TX: trx_reg <= prod_x[31:24];
            B_TY: try_reg <= prod_y[31:24];
            default:
            begin
            end
        endcase
        if (state_reg == B_OUT && (!out_valid || out_ready))
        begin
            out_blue  <= 8'd128 + z_reg[23:16];
            out_green <= 8'd128 - try_s;
            out_red   <= 8'd128 - trx_s;
            out_row   <= job_reg.row;
            out_col   <= job_reg.col;
            out_last  <= job_reg.last;
            out_eof   <= job_reg.eof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (state_reg == B_OUT && (!out_valid || out_ready))
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: if (!q_stat.empty) state_reg <= B_MULX;
                B_MULX: state_reg <= B_MULY;
                B_MULY: state_reg <= B_SQX;
                B_SQX:  state_reg <= B_SQY;
                B_SQY:  state_reg <= B_SUM;
                B_SUM:
                begin
                    cnt_reg   <= 6'd48;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= B_SQRT;
                    end
                end
                B_SQRT: if (bit_reg[0]) state_reg <= B_Z;
                B_Z:    state_reg <= B_TX;
                B_TX:   state_reg <= B_TY;
                B_TY:   state_reg <= B_OUT;
                B_OUT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/height_to_normal_map.sv =====
// height map to normal map converter
// slave stream: one 8-bit height sample per transaction, raster order
// master stream: one normal pixel per transaction; tlast marks the last pixel
// caused by an input sample, tuser marks the final pixel of the image
// apb port: image_width at 0x0, image_height at 0x4, strength (q8.8) at 0x8;
// writing width or height restarts the frame at row 0, column 0
// results of a row come out while the row below streams in; the last row
// comes out one pixel behind its input, its final pixel with the final input
// the front takes a new input sample only after it is done with the last (two
// line store reads, a write, three job slots); the normal unit takes a new job
// only after handing its result to the output register, working through the
// 49-step divider and the 17-step square root; a sample makes zero to three
// results, a 4-entry job queue sits between them
// a stalled master side fills the output register, then the job queue, then
// holds slave tready low; no transaction is lost
// reset clears counters, queue and output valid; line store contents are not
// cleared, and registers return to width 1, height 1, strength 1.0
module height_to_normal_map import hnm_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] height_sample
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // blue_z, green_y, red_x, out_row, out_column, zero pad
    output logic        m_tlast,
    output logic        m_tuser     // end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH+1);

    logic [10:0]        image_width_reg;
    logic [15:0]        image_height_reg;
    logic signed [15:0] strength_reg;
    logic               cfg_wr, geom_clear;
    logic [CW-1:0]      width_eff;
    logic [15:0]        height_eff;

    // job queue between front and normal unit
    fifo_stat_t q_stat;
    logic       q_push, q_pop;
    job_t       q_job, q_head;

    logic [7:0]  o_blue, o_green, o_red;
    logic [15:0] o_row;
    logic [9:0]  o_col;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign geom_clear = cfg_wr && (paddr[3:2] == REG_IMAGE_WIDTH ||
                                   paddr[3:2] == REG_IMAGE_HEIGHT);

    // width 0 acts as 1, above the line store size it is clamped
    assign width_eff  = (image_width_reg == 11'd0) ? CW'(1) :
                        ({21'd0, image_width_reg} > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) :
                        CW'(image_width_reg);
    assign height_eff = (image_height_reg == 16'd0) ? 16'd1 : image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd1;
            image_height_reg <= 16'd1;
            strength_reg     <= 16'sd256;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[15:0];
                REG_STRENGTH:     strength_reg     <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = {21'd0, image_width_reg};
            REG_IMAGE_HEIGHT: prdata = {16'd0, image_height_reg};
            REG_STRENGTH:     prdata = {16'd0, strength_reg};
            default:          prdata = 32'd0;
        endcase
    end

    hnm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .geom_clear (geom_clear),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_job      (q_job)
    );

    hnm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    hnm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .strength  (strength_reg),
        .q_stat    (q_stat),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_blue  (o_blue),
        .out_green (o_green),
        .out_red   (o_red),
        .out_row   (o_row),
        .out_col   (o_col),
        .out_last  (m_tlast),
        .out_eof   (m_tuser)
    );

    assign m_tdata = {6'd0, o_col, o_row, o_red, o_green, o_blue};

    // the front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("job pushed into full queue");

    // the final pixel of the image always closes its transaction run
    assert property (@(posedge clk) disable iff (!rst_n) (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end of frame without tlast");

    // after taking a sample the front is busy with it
    assert property (@(posedge clk) disable iff (!rst_n) (s_tvalid && s_tready) |=> !s_tready)
        else $error("front accepted a sample while busy");

endmodule
